// ===== hw/rtl/gregorian_date_arithmetic_core_defines.svh =====
// Assertion macros shared by the date arithmetic core.
`ifndef GREGORIAN_DATE_ARITHMETIC_CORE_DEFINES_SVH
`define GREGORIAN_DATE_ARITHMETIC_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GDAC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GDAC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/gdac_pkg.sv =====
package gdac_pkg;

   // Field widths of the request and response beats.
   localparam int MODE_W  = 3;
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int COUNT_W = 22;
   localparam int DOY_W   = 9;
   localparam int LEAPS_W = 12;
   localparam int INDEX_W = 23;
   localparam int LIMIT_W = 16;

   localparam int MAX_YEAR_DEFAULT = 9999;

   localparam logic [DOY_W-1:0]   DAYS_PER_YEAR = 9'd365;
   localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 22'h3FFFFF;

   // Reciprocal of 25 scaled by 2^17, exact for inputs below 4096.
   localparam logic [12:0] RECIP_25 = 13'd5243;
   // Reciprocal of 7 scaled by 2^11, exact for inputs below 373.
   localparam logic [8:0]  RECIP_7 = 9'd293;

   typedef enum logic [MODE_W-1:0] {
      MODE_NEXT     = 3'd0,
      MODE_PREV     = 3'd1,
      MODE_DOY      = 3'd2,
      MODE_WEEK     = 3'd3,
      MODE_ANNIV    = 3'd4,
      MODE_SPAN     = 3'd5,
      MODE_VALIDATE = 3'd6
   } mode_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
      logic [DAY_W-1:0]   other_day;
      logic [MONTH_W-1:0] other_month;
      logic [YEAR_W-1:0]  other_year;
   } req_beat_type;

   typedef struct packed {
      logic [DAY_W-1:0]   res_day;
      logic [MONTH_W-1:0] res_month;
      logic [YEAR_W-1:0]  res_year;
      logic [COUNT_W-1:0] count;
      logic               flag;
   } rsp_beat_type;

   // Days in the months before the given month of a common year.
   function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
      logic [DOY_W-1:0] r;
      unique case (m)
         4'd1:    r = 9'd0;
         4'd2:    r = 9'd31;
         4'd3:    r = 9'd59;
         4'd4:    r = 9'd90;
         4'd5:    r = 9'd120;
         4'd6:    r = 9'd151;
         4'd7:    r = 9'd181;
         4'd8:    r = 9'd212;
         4'd9:    r = 9'd243;
         4'd10:   r = 9'd273;
         4'd11:   r = 9'd304;
         4'd12:   r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   // Length of a month; February grows by one in leap years.
   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
      logic [DAY_W-1:0] r;
      unique case (m)
         4'd2:                      r = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
         default:                   r = 5'd31;
      endcase
      return r;
   endfunction

   // Quotient of a 12-bit value by 25 through a scaled reciprocal.
   function automatic logic [7:0] div25(input logic [11:0] x);
      logic [24:0] p;
      p = 25'(x) * 25'(RECIP_25);
      return p[24:17];
   endfunction

   // Gregorian leap rule: y/4 is split into hundreds and a remainder below 25.
   function automatic logic is_leap(input logic [YEAR_W-1:0] y);
      logic [7:0]  q;
      logic [11:0] r;
      q = div25(y[YEAR_W-1:2]);
      r = y[YEAR_W-1:2] - 12'(q) * 12'd25;
      return (y[1:0] == 2'b00) && ((r != 12'd0) || (q[1:0] == 2'b00));
   endfunction

   // Number of leap years in [0, y).
   function automatic logic [LEAPS_W-1:0] leaps_before(input logic [YEAR_W-1:0] y);
      logic [YEAR_W-1:0] ym;
      logic [12:0]       sum;
      ym  = y - 14'd1;
      sum = {1'b0, ym[YEAR_W-1:2]} - 13'(div25(ym[YEAR_W-1:2]))
            + 13'(div25({2'b00, ym[YEAR_W-1:4]})) + 13'd1;
      return (y == '0) ? '0 : sum[LEAPS_W-1:0];
   endfunction

   // Day of year, 1-based; the month must lie in 1..12.
   function automatic logic [DOY_W-1:0] day_of_year(input logic [DAY_W-1:0] d,
                                                    input logic [MONTH_W-1:0] m,
                                                    input logic leap);
      logic bump;
      bump = leap && (m > 4'd2);
      return days_before(m) + DOY_W'(d) + DOY_W'(bump);
   endfunction

   // Day number, counted from 1 on the first day of year zero.
   function automatic logic [INDEX_W-1:0] day_index(input logic [DAY_W-1:0] d,
                                                    input logic [MONTH_W-1:0] m,
                                                    input logic [YEAR_W-1:0] y,
                                                    input logic leap);
      logic [INDEX_W-1:0] base;
      base = INDEX_W'(y) * INDEX_W'(DAYS_PER_YEAR);
      return base + INDEX_W'(leaps_before(y)) + INDEX_W'(day_of_year(d, m, leap));
   endfunction

endpackage

// ===== hw/rtl/gdac_stream_if.sv =====
// Valid/ready channel carrying one beat of the given payload type.
interface gdac_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/gdac_calc.sv =====
// Date evaluation for one request beat, purely combinational.
module gdac_calc #(
   parameter int MAX_YEAR = gdac_pkg::MAX_YEAR_DEFAULT
) (
   input  gdac_pkg::req_beat_type req,
   output gdac_pkg::rsp_beat_type rsp
);

   localparam logic [gdac_pkg::LIMIT_W-1:0] MaxYear = gdac_pkg::LIMIT_W'(MAX_YEAR);

   logic [gdac_pkg::YEAR_W-1:0]  year_next;
   logic [gdac_pkg::YEAR_W-1:0]  year_prev;
   logic [gdac_pkg::MONTH_W-1:0] month_prev;
   logic                         leap_pri;
   logic                         leap_next;
   logic                         leap_oth;
   logic [gdac_pkg::DAY_W-1:0]   len_pri;
   logic [gdac_pkg::DAY_W-1:0]   len_prev;
   logic [gdac_pkg::DAY_W-1:0]   len_oth;
   logic [gdac_pkg::DAY_W-1:0]   len_anniv;
   logic                         pri_ok;
   logic                         oth_ok;
   logic                         anniv_ok;
   logic                         at_max_year;
   logic [gdac_pkg::DOY_W-1:0]   doy_pri;
   logic [gdac_pkg::DOY_W-1:0]   doy_anniv;
   logic [gdac_pkg::DOY_W-1:0]   doy_anniv_next;
   logic [gdac_pkg::DOY_W-1:0]   week_sum;
   logic [17:0]                  week_prod;
   logic [9:0]                   anniv_wrap;
   logic [gdac_pkg::INDEX_W-1:0] idx_pri;
   logic [gdac_pkg::INDEX_W-1:0] idx_oth;
   logic [gdac_pkg::INDEX_W-1:0] span;
   logic [gdac_pkg::DAY_W-1:0]   rd;
   logic [gdac_pkg::MONTH_W-1:0] rm;
   logic [gdac_pkg::YEAR_W-1:0]  ry;
   logic [gdac_pkg::COUNT_W-1:0] cnt;
   logic                         bad;

   // Leap flags and month lengths for both dates.
   assign year_next  = req.year + 14'd1;
   assign year_prev  = req.year - 14'd1;
   assign month_prev = req.month - 4'd1;
   assign leap_pri   = gdac_pkg::is_leap(req.year);
   assign leap_next  = gdac_pkg::is_leap(year_next);
   assign leap_oth   = gdac_pkg::is_leap(req.other_year);
   assign len_pri    = gdac_pkg::month_length(req.month, leap_pri);
   assign len_prev   = gdac_pkg::month_length(month_prev, leap_pri);
   assign len_oth    = gdac_pkg::month_length(req.other_month, leap_oth);
   assign len_anniv  = gdac_pkg::month_length(req.other_month, 1'b1);

   // Validity checks; an anniversary ignores its year and allows the 29th of February.
   assign pri_ok = ({2'b00, req.year} <= MaxYear) && (req.month >= 4'd1)
                   && (req.month <= gdac_pkg::MONTHS_PER_YEAR)
                   && (req.day >= 5'd1) && (req.day <= len_pri);
   assign oth_ok = ({2'b00, req.other_year} <= MaxYear) && (req.other_month >= 4'd1)
                   && (req.other_month <= gdac_pkg::MONTHS_PER_YEAR)
                   && (req.other_day >= 5'd1) && (req.other_day <= len_oth);
   assign anniv_ok = (req.other_month >= 4'd1)
                     && (req.other_month <= gdac_pkg::MONTHS_PER_YEAR)
                     && (req.other_day >= 5'd1) && (req.other_day <= len_anniv);
   assign at_max_year = ({2'b00, req.year} >= MaxYear);

   // Day-of-year values, week number and the wrapped anniversary distance.
   assign doy_pri        = gdac_pkg::day_of_year(req.day, req.month, leap_pri);
   assign doy_anniv      = gdac_pkg::day_of_year(req.other_day, req.other_month, leap_pri);
   assign doy_anniv_next = gdac_pkg::day_of_year(req.other_day, req.other_month, leap_next);
   assign week_sum       = doy_pri + 9'd6;
   assign week_prod      = 18'(week_sum) * 18'(gdac_pkg::RECIP_7);
   assign anniv_wrap     = 10'(doy_anniv_next) + 10'(gdac_pkg::DAYS_PER_YEAR)
                           + 10'(leap_pri) - 10'(doy_pri);

   // Absolute distance between the two day indexes.
   assign idx_pri = gdac_pkg::day_index(req.day, req.month, req.year, leap_pri);
   assign idx_oth = gdac_pkg::day_index(req.other_day, req.other_month, req.other_year,
                                        leap_oth);
   assign span    = (idx_pri >= idx_oth) ? (idx_pri - idx_oth) : (idx_oth - idx_pri);

   // Mode selection.
   always_comb begin
      rd  = '0;
      rm  = '0;
      ry  = '0;
      cnt = '0;
      bad = !pri_ok;
      unique case (gdac_pkg::mode_type'(req.mode))
         gdac_pkg::MODE_NEXT: begin
            ry = req.year;
            if (req.day == len_pri) begin
               rd = 5'd1;
               if (req.month == gdac_pkg::MONTHS_PER_YEAR) begin
                  rm  = 4'd1;
                  ry  = year_next;
                  bad = bad || at_max_year;
               end else begin
                  rm = req.month + 4'd1;
               end
            end else begin
               rd = req.day + 5'd1;
               rm = req.month;
            end
         end
         gdac_pkg::MODE_PREV: begin
            ry = req.year;
            if (req.day == 5'd1) begin
               if (req.month == 4'd1) begin
                  rm  = gdac_pkg::MONTHS_PER_YEAR;
                  rd  = 5'd31;
                  ry  = year_prev;
                  bad = bad || (req.year == '0);
               end else begin
                  rm = month_prev;
                  rd = len_prev;
               end
            end else begin
               rd = req.day - 5'd1;
               rm = req.month;
            end
         end
         gdac_pkg::MODE_DOY: begin
            cnt = gdac_pkg::COUNT_W'(doy_pri);
         end
         gdac_pkg::MODE_WEEK: begin
            cnt = gdac_pkg::COUNT_W'(week_prod[17:11]);
         end
         gdac_pkg::MODE_ANNIV: begin
            bad = bad || !anniv_ok;
            if (doy_anniv >= doy_pri) begin
               cnt = gdac_pkg::COUNT_W'(doy_anniv - doy_pri);
            end else begin
               cnt = gdac_pkg::COUNT_W'(anniv_wrap);
            end
         end
         gdac_pkg::MODE_SPAN: begin
            bad = bad || !oth_ok;
            if (span > gdac_pkg::INDEX_W'(gdac_pkg::COUNT_MAX)) begin
               cnt = gdac_pkg::COUNT_MAX;
            end else begin
               cnt = span[gdac_pkg::COUNT_W-1:0];
            end
         end
         gdac_pkg::MODE_VALIDATE: begin
            cnt = '0;
         end
         default: begin
            bad = 1'b1;
         end
      endcase
   end

   // A flagged result carries zeros in every other field.
   always_comb begin
      rsp.flag      = bad;
      rsp.res_day   = bad ? '0 : rd;
      rsp.res_month = bad ? '0 : rm;
      rsp.res_year  = bad ? '0 : ry;
      rsp.count     = bad ? '0 : cnt;
   end

endmodule

// ===== hw/rtl/gregorian_date_arithmetic_core.sv =====
// Gregorian date arithmetic core.
// Requests arrive on req_ch (valid/ready); each beat holds a mode, a primary
// date and a second date. Every request beat yields exactly one response beat
// on rsp_ch with a result date, a count and an error flag, in request order.
// Modes: next day, previous day, day of year, week of year, days to the next
// anniversary of the second date, days between the dates, and validation.
// A request beat is captured in an input register; the date logic sits between
// that register and the response register, which holds the beat offered on
// rsp_ch; one beat is accepted every cycle while the sink keeps ready high.
// Throughput is set by the single response register: if the sink stalls while
// it is full, req_ch.ready drops in the same cycle; both keep their beats.
// Synchronous reset empties both registers; no response is pending afterward
// and the core can take a request in the first cycle after reset.
`include "gregorian_date_arithmetic_core_defines.svh"

module gregorian_date_arithmetic_core #(
   parameter int MAX_YEAR = gdac_pkg::MAX_YEAR_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   gdac_stream_if.sink   req_ch,
   gdac_stream_if.source rsp_ch
);

   logic                   advance;
   logic                   req_valid_ff;
   logic                   req_valid_in;
   gdac_pkg::req_beat_type req_data_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   gdac_pkg::rsp_beat_type rsp_data_ff;
   gdac_pkg::rsp_beat_type rsp_data_in;
   logic                   beat_moves;
   logic                   beat_stalls;
   logic                   rsp_flagged;
   logic                   rsp_counted;
   logic                   rsp_date_zero;
   logic                   rsp_fields_zero;

   // The pipeline moves whenever the response register is empty or drained.
   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign req_valid_in = advance ? req_ch.valid : req_valid_ff;
   assign rsp_valid_in = advance ? req_valid_ff : rsp_valid_ff;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
      if (advance && req_ch.valid) begin
         req_data_ff <= req_ch.data;
      end
   end

   // Date evaluation.
   gdac_calc #(
      .MAX_YEAR (MAX_YEAR)
   ) u_calc (
      .req (req_data_ff),
      .rsp (rsp_data_in)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance && req_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   // Terms used by the pipeline checks.
   assign beat_moves      = req_valid_ff && advance;
   assign beat_stalls     = req_valid_ff && !advance;
   assign rsp_flagged     = rsp_valid_ff && rsp_data_ff.flag;
   assign rsp_counted     = rsp_valid_ff && (rsp_data_ff.count != '0);
   assign rsp_date_zero   = (rsp_data_ff.res_day == '0) && (rsp_data_ff.res_month == '0)
                            && (rsp_data_ff.res_year == '0);
   assign rsp_fields_zero = rsp_date_zero && (rsp_data_ff.count == '0);

   // Checks on the internal pipeline.
   `GDAC_ASSERT_NEXT(a_beat_moves_on, clock, reset, beat_moves, rsp_valid_ff, "beat lost")
   `GDAC_ASSERT_NEXT(a_beat_held, clock, reset, beat_stalls, req_valid_ff, "beat dropped")
   `GDAC_ASSERT_SAME(a_flag_zeroes, clock, reset, rsp_flagged, rsp_fields_zero, "flag with data")
   `GDAC_ASSERT_SAME(a_date_or_count, clock, reset, rsp_counted, rsp_date_zero, "date and count")

endmodule

// ===== bench/date_result_checker.sv =====
`timescale 1ns / 1ps

module date_result_checker
   import gdac_pkg::*;
#(
   parameter int unsigned LAST_YEAR = MAX_YEAR_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_beat_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_beat_type rsp_data,
   output int           outstanding,
   output int           failures
);

   rsp_beat_type pending_answers[$];
   rsp_beat_type want;
   int           fail_tally = 0;

   // Gregorian rule: every fourth year, but only every fourth century.
   function automatic bit leap_year(input int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int unsigned month_days(input int unsigned m, input bit leap);
      case (m)
         2:           return leap ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:     return 31;
      endcase
   endfunction

   // Day of the year counted from 1; the month must lie in 1..12.
   function automatic int unsigned ordinal_day(input int unsigned d, input int unsigned m,
                                               input bit leap);
      int unsigned total;
      total = d;
      for (int unsigned k = 1; k < m; k++) total += month_days(k, leap);
      return total;
   endfunction

   function automatic bit date_valid(input int unsigned d, input int unsigned m,
                                     input int unsigned y);
      if (y > LAST_YEAR || m < 1 || m > 12 || d < 1) return 1'b0;
      return d <= month_days(m, leap_year(y));
   endfunction

   // Leap years strictly below y, year zero included.
   function automatic int unsigned leaps_below(input int unsigned y);
      if (y == 0) return 0;
      return (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400 + 1;
   endfunction

   function automatic int unsigned day_number(input int unsigned d, input int unsigned m,
                                              input int unsigned y);
      return 365 * y + leaps_below(y) + ordinal_day(d, m, leap_year(y));
   endfunction

   // Expected response beat for one request beat.
   function automatic rsp_beat_type date_answer(input req_beat_type b);
      int unsigned  d, m, y, od, om, oy;
      int unsigned  nd, nm, ny, tally, today, target, lo, hi;
      bit           bad, leap;
      rsp_beat_type r;
      d = b.day;
      m = b.month;
      y = b.year;
      od = b.other_day;
      om = b.other_month;
      oy = b.other_year;
      nd = 0;
      nm = 0;
      ny = 0;
      tally = 0;
      bad = !date_valid(d, m, y);
      leap = leap_year(y);
      if (!bad) begin
         case (b.mode)
            MODE_NEXT: begin
               nd = d + 1;
               nm = m;
               ny = y;
               if (nd > month_days(m, leap)) begin
                  nd = 1;
                  nm = m + 1;
                  if (nm > 12) begin
                     nm = 1;
                     if (y >= LAST_YEAR) bad = 1'b1;
                     else ny = y + 1;
                  end
               end
            end
            MODE_PREV: begin
               nm = m;
               ny = y;
               if (d > 1) begin
                  nd = d - 1;
               end else if (m == 1 && y == 0) begin
                  bad = 1'b1;
               end else begin
                  if (m == 1) begin
                     nm = 12;
                     ny = y - 1;
                  end else begin
                     nm = m - 1;
                  end
                  // Stepping back into February picks up the leap day when there is one.
                  nd = month_days(nm, leap_year(ny));
               end
            end
            MODE_DOY: tally = ordinal_day(d, m, leap);
            MODE_WEEK: tally = (ordinal_day(d, m, leap) + 6) / 7;
            MODE_ANNIV: begin
               // The anniversary accepts 29 February whatever the year.
               if (om < 1 || om > 12 || od < 1 || od > month_days(om, 1'b1)) begin
                  bad = 1'b1;
               end else begin
                  today = ordinal_day(d, m, leap);
                  target = ordinal_day(od, om, leap);
                  if (target >= today) tally = target - today;
                  else tally = ordinal_day(od, om, leap_year(y + 1)) + 365 + leap - today;
               end
            end
            MODE_SPAN: begin
               if (!date_valid(od, om, oy)) begin
                  bad = 1'b1;
               end else begin
                  lo = day_number(d, m, y);
                  hi = day_number(od, om, oy);
                  tally = (lo >= hi) ? lo - hi : hi - lo;
                  if (tally > COUNT_MAX) tally = COUNT_MAX;
               end
            end
            MODE_VALIDATE: ;
            default: bad = 1'b1;
         endcase
      end
      if (bad) begin
         nd = 0;
         nm = 0;
         ny = 0;
         tally = 0;
      end
      r.res_day = DAY_W'(nd);
      r.res_month = MONTH_W'(nm);
      r.res_year = YEAR_W'(ny);
      r.count = COUNT_W'(tally);
      r.flag = bad;
      return r;
   endfunction

   // One line per mismatch, and every mismatch is counted.
   task automatic report_mismatch(input string line);
      $display("%0t: %s", $realtime, line);
      fail_tally++;
   endtask

   task automatic check_field(input string field, input logic [31:0] got,
                              input logic [31:0] exp);
      if (got !== exp)
         report_mismatch($sformatf("response %s is %0d, expected %0d", field, got, exp));
   endtask

   // Response beats are matched in order against the oldest prediction.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_answers.size() == 0) begin
               report_mismatch("response beat with no request waiting");
            end else begin
               want = pending_answers.pop_front();
               check_field("day", 32'(rsp_data.res_day), 32'(want.res_day));
               check_field("month", 32'(rsp_data.res_month), 32'(want.res_month));
               check_field("year", 32'(rsp_data.res_year), 32'(want.res_year));
               check_field("count", 32'(rsp_data.count), 32'(want.count));
               check_field("flag", 32'(rsp_data.flag), 32'(want.flag));
            end
         end
         if (req_valid && req_ready) pending_answers.push_back(date_answer(req_data));
      end
      outstanding <= pending_answers.size();
      failures <= fail_tally;
   end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import gdac_pkg::*;

   localparam int    RESET_CYCLES = 7;
   localparam int    DRAIN_CYCLES = 10;
   localparam int    RANDOM_BEATS = 1400;
   localparam int    PHASE_BEATS = 100;
   localparam int    MODE_UNUSED = 7;
   localparam longint TIMEOUT_NS = 64'd6_000_000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         send_valid = 1'b0;
   req_beat_type send_data = '0;
   logic         take_ready = 1'b0;
   bit           steady = 1'b0;
   int           ready_hold = 0;
   int           stall_len;
   int           outstanding;
   int           failures;

   gdac_stream_if #(.payload_type(req_beat_type)) req_ch ();
   gdac_stream_if #(.payload_type(rsp_beat_type)) rsp_ch ();

   assign req_ch.valid = send_valid;
   assign req_ch.data = send_data;
   assign rsp_ch.ready = take_ready;

   gregorian_date_arithmetic_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   date_result_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ch.ready),
      .req_data    (req_ch.data),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_data    (rsp_ch.data),
      .outstanding (outstanding),
      .failures    (failures)
   );

   // Clock with a 12 ns period.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Idle stretch length: usually none or short, now and then long.
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic req_beat_type make_beat(input int mode, input int d, input int m,
                                              input int y, input int od, input int om,
                                              input int oy);
      req_beat_type b;
      b.mode = MODE_W'(mode);
      b.day = DAY_W'(d);
      b.month = MONTH_W'(m);
      b.year = YEAR_W'(y);
      b.other_day = DAY_W'(od);
      b.other_month = MONTH_W'(om);
      b.other_year = YEAR_W'(oy);
      return b;
   endfunction

   // Any bit pattern at all, including modes and dates that are out of range.
   function automatic req_beat_type noise_beat();
      return make_beat($urandom_range(0, 7), $urandom_range(0, 31), $urandom_range(0, 15),
                       $urandom_range(0, 16383), $urandom_range(0, 31),
                       $urandom_range(0, 15), $urandom_range(0, 16383));
   endfunction

   // Days lean toward the first and the last days of a month.
   function automatic int pick_day();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 15) return 1;
      if (roll < 40) return $urandom_range(28, 31);
      return $urandom_range(1, 28);
   endfunction

   // Years lean toward century and range edges and toward leap candidates.
   function automatic int pick_year();
      int edges[13] = '{0, 1, 4, 99, 100, 400, 1600, 1900, 2000, 2024, 9996, 9998, 9999};
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 20) return edges[$urandom_range(0, 12)];
      if (roll < 35) return 4 * $urandom_range(0, 2499);
      return $urandom_range(0, 9999);
   endfunction

   function automatic req_beat_type random_request();
      if ($urandom_range(0, 99) < 10) return noise_beat();
      return make_beat($urandom_range(0, 6), pick_day(), $urandom_range(1, 12), pick_year(),
                       pick_day(), $urandom_range(1, 12), pick_year());
   endfunction

   // Offers one request beat after an optional idle gap and waits for its acceptance.
   task automatic send_request(input req_beat_type b);
      int gap;
      gap = steady ? 0 : idle_length();
      if (gap > 0) begin
         send_valid <= 1'b0;
         send_data <= noise_beat();
         repeat (gap) @(posedge clock);
      end
      send_valid <= 1'b1;
      send_data <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Response side: runs of ready cycles broken by stalls, none in steady phases.
   always @(posedge clock) begin
      if (reset) begin
         take_ready <= 1'b0;
         ready_hold <= 0;
      end else if (steady) begin
         take_ready <= 1'b1;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if (take_ready) begin
         stall_len = idle_length();
         if (stall_len > 0) begin
            take_ready <= 1'b0;
            ready_hold <= stall_len - 1;
         end else begin
            ready_hold <= $urandom_range(0, 7);
         end
      end else begin
         take_ready <= 1'b1;
         ready_hold <= $urandom_range(0, 11);
      end
   end

   // Stimulus: directed corner dates first, then random beats, then the verdict.
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Stepping off both ends of the year range.
      send_request(make_beat(MODE_NEXT, 31, 12, 9999, 0, 0, 0));
      send_request(make_beat(MODE_PREV, 1, 1, 0, 0, 0, 0));
      // Stepping back into February in leap and century years, then around February and 2000.
      send_request(make_beat(MODE_PREV, 1, 3, 2024, 0, 0, 0));
      send_request(make_beat(MODE_PREV, 1, 3, 1900, 0, 0, 0));
      send_request(make_beat(MODE_NEXT, 28, 2, 2000, 0, 0, 0));
      send_request(make_beat(MODE_NEXT, 29, 2, 2000, 0, 0, 0));
      send_request(make_beat(MODE_NEXT, 31, 12, 1999, 0, 0, 0));
      send_request(make_beat(MODE_PREV, 1, 1, 2000, 0, 0, 0));
      // Validation of leap days and of malformed dates.
      send_request(make_beat(MODE_VALIDATE, 29, 2, 2000, 0, 0, 0));
      send_request(make_beat(MODE_VALIDATE, 29, 2, 1900, 0, 0, 0));
      send_request(make_beat(MODE_VALIDATE, 0, 5, 2020, 0, 0, 0));
      send_request(make_beat(MODE_VALIDATE, 10, 0, 2020, 0, 0, 0));
      send_request(make_beat(MODE_VALIDATE, 10, 13, 2020, 0, 0, 0));
      send_request(make_beat(MODE_VALIDATE, 31, 4, 2020, 0, 0, 0));
      send_request(make_beat(MODE_VALIDATE, 1, 1, 10000, 0, 0, 0));
      send_request(make_beat(MODE_VALIDATE, 31, 15, 16383, 31, 15, 16383));
      // Day and week of the year.
      send_request(make_beat(MODE_DOY, 31, 12, 2024, 0, 0, 0));
      send_request(make_beat(MODE_WEEK, 31, 12, 2024, 0, 0, 0));
      // Anniversaries: leap day in a common year, wrap into next year, bad and same day.
      send_request(make_beat(MODE_ANNIV, 1, 1, 2023, 29, 2, 0));
      send_request(make_beat(MODE_ANNIV, 15, 6, 2023, 1, 1, 0));
      send_request(make_beat(MODE_ANNIV, 31, 12, 9999, 1, 1, 0));
      send_request(make_beat(MODE_ANNIV, 5, 5, 2021, 30, 2, 0));
      send_request(make_beat(MODE_ANNIV, 5, 5, 2021, 5, 5, 77));
      // Longest span both ways, and a span to an invalid date.
      send_request(make_beat(MODE_SPAN, 1, 1, 0, 31, 12, 9999));
      send_request(make_beat(MODE_SPAN, 31, 12, 9999, 1, 1, 0));
      send_request(make_beat(MODE_SPAN, 1, 1, 2000, 29, 2, 2001));
      send_request(make_beat(MODE_UNUSED, 1, 1, 2000, 1, 1, 2000));

      // Random beats, with occasional phases that run without any idling.
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % PHASE_BEATS == 0) steady <= ($urandom_range(0, 3) == 0);
         send_request(random_request());
      end
      send_valid <= 1'b0;

      // Drain every outstanding response, then allow for the pipeline latency.
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(TIMEOUT_NS);
      $display("Some tests failed");
      $finish;
   end

endmodule
